// ===== hdl/ipdfr_pkg.sv =====
package ipdfr_pkg;

  // frame size limits
  localparam int MAX_FRAME_BYTES = 8;
  localparam int DEF_FRAME_BYTES = 6;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int TICK_W     = 6;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_LEADER_LOW_MIN  = 3'd0;
  localparam logic [2:0] REG_LEADER_LOW_MAX  = 3'd1;
  localparam logic [2:0] REG_LEADER_HIGH_MIN = 3'd2;
  localparam logic [2:0] REG_LEADER_HIGH_MAX = 3'd3;
  localparam logic [2:0] REG_BIT_LOW_MAX     = 3'd4;
  localparam logic [2:0] REG_ONE_HIGH_MIN    = 3'd5;
  localparam logic [2:0] REG_ZERO_HIGH_MAX   = 3'd6;
  localparam logic [2:0] REG_BIT_HIGH_MAX    = 3'd7;

  // register reset values
  localparam logic [TICK_W-1:0] RST_LEADER_LOW_MIN  = 6'd15;
  localparam logic [TICK_W-1:0] RST_LEADER_LOW_MAX  = 6'd25;
  localparam logic [TICK_W-1:0] RST_LEADER_HIGH_MIN = 6'd35;
  localparam logic [TICK_W-1:0] RST_LEADER_HIGH_MAX = 6'd45;
  localparam logic [TICK_W-1:0] RST_BIT_LOW_MAX     = 6'd4;
  localparam logic [TICK_W-1:0] RST_ONE_HIGH_MIN    = 6'd7;
  localparam logic [TICK_W-1:0] RST_ZERO_HIGH_MAX   = 6'd3;
  localparam logic [TICK_W-1:0] RST_BIT_HIGH_MAX    = 6'd8;

  // fixed timing constants
  localparam logic [TICK_W-1:0] TICK_MAX      = 6'd63;
  localparam logic [TICK_W-1:0] ZERO_HIGH_MIN = 6'd2;
  localparam logic [3:0]        BYTE_BITS     = 4'd8;

  // timing windows
  typedef struct packed {
    logic [TICK_W-1:0] leader_low_min;
    logic [TICK_W-1:0] leader_low_max;
    logic [TICK_W-1:0] leader_high_min;
    logic [TICK_W-1:0] leader_high_max;
    logic [TICK_W-1:0] bit_low_max;
    logic [TICK_W-1:0] one_high_min;
    logic [TICK_W-1:0] zero_high_max;
    logic [TICK_W-1:0] bit_high_max;
  } cfg_t;

  // completed frame handed from the decoder to the formatter
  typedef struct packed {
    logic                                fire;
    logic [MAX_FRAME_BYTES-1:0][7:0]     data;
  } frame_t;

  // saturating tick count
  function automatic logic [TICK_W-1:0] bump(input logic [TICK_W-1:0] v);
    bump = (v == TICK_MAX) ? TICK_MAX : v + 1'b1;
  endfunction

  // reverse bit order of a byte
  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    flip8 = r;
  endfunction

endpackage

// ===== hdl/ir_pulse_distance_frame_receiver.sv =====
// Pulse-distance infrared frame receiver.
//
// Input channel: one sampled line level (ir_level, 0 = carrier on) per item,
// accepted when in_valid is high and in_stall is low. The block decodes a
// leader (low then high window), then bits as short low plus high, MSB first,
// and collects FRAME_BYTES bytes.
// Output channel: one item per completed frame with each byte bit reversed
// and sum_ok set when bytes one to four add up (mod 256) to the check byte;
// taken when out_valid is high and out_stall is low.
// Throughput: one line sample per cycle while in_stall is low, set by the single decode pass
// between the state registers and the result register.
// Output timing: the result is registered and shown in the cycle after the sample that ends the frame.
// Stall: a result waiting under out_stall holds in_stall high; as soon as it
// is taken the next sample is accepted in the same cycle.
// Configuration: eight 6-bit timing windows on an APB port at 4*index; the user must write them
// only while the line is idle, as the block itself does not enforce it.
// Reset (synchronous, rst): decoder returns to idle, counters clear, timing
// windows take their default values; the byte store needs no clearing.
module ir_pulse_distance_frame_receiver
  import ipdfr_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  ir_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            start_byte,
  output logic [7:0]            data_byte_one,
  output logic [7:0]            data_byte_two,
  output logic [7:0]            data_byte_three,
  output logic [7:0]            data_byte_four,
  output logic [7:0]            check_byte,
  output logic                  sum_ok
);

  cfg_t   cfg;
  frame_t frame;
  logic   step;

  // hold off samples only while a result waits under stall
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  ipdfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipdfr_decoder #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_decoder (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .ir_level (ir_level),
    .cfg      (cfg),
    .frame    (frame)
  );

  ipdfr_format #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_format (
    .clk             (clk),
    .rst             (rst),
    .frame           (frame),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .start_byte      (start_byte),
    .data_byte_one   (data_byte_one),
    .data_byte_two   (data_byte_two),
    .data_byte_three (data_byte_three),
    .data_byte_four  (data_byte_four),
    .check_byte      (check_byte),
    .sum_ok          (sum_ok)
  );

endmodule

// ===== hdl/ipdfr_regs.sv =====
module ipdfr_regs
  import ipdfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic              wr_en;
  logic [2:0]        reg_idx;
  logic [TICK_W-1:0] rd_val;
  logic [TICK_W-1:0] wr_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];
  assign wr_val  = pwdata[TICK_W-1:0];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_low_min  <= RST_LEADER_LOW_MIN;
      cfg.leader_low_max  <= RST_LEADER_LOW_MAX;
      cfg.leader_high_min <= RST_LEADER_HIGH_MIN;
      cfg.leader_high_max <= RST_LEADER_HIGH_MAX;
      cfg.bit_low_max     <= RST_BIT_LOW_MAX;
      cfg.one_high_min    <= RST_ONE_HIGH_MIN;
      cfg.zero_high_max   <= RST_ZERO_HIGH_MAX;
      cfg.bit_high_max    <= RST_BIT_HIGH_MAX;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEADER_LOW_MIN:  cfg.leader_low_min  <= wr_val;
        REG_LEADER_LOW_MAX:  cfg.leader_low_max  <= wr_val;
        REG_LEADER_HIGH_MIN: cfg.leader_high_min <= wr_val;
        REG_LEADER_HIGH_MAX: cfg.leader_high_max <= wr_val;
        REG_BIT_LOW_MAX:     cfg.bit_low_max     <= wr_val;
        REG_ONE_HIGH_MIN:    cfg.one_high_min    <= wr_val;
        REG_ZERO_HIGH_MAX:   cfg.zero_high_max   <= wr_val;
        REG_BIT_HIGH_MAX:    cfg.bit_high_max    <= wr_val;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_LEADER_LOW_MIN:  rd_val = cfg.leader_low_min;
      REG_LEADER_LOW_MAX:  rd_val = cfg.leader_low_max;
      REG_LEADER_HIGH_MIN: rd_val = cfg.leader_high_min;
      REG_LEADER_HIGH_MAX: rd_val = cfg.leader_high_max;
      REG_BIT_LOW_MAX:     rd_val = cfg.bit_low_max;
      REG_ONE_HIGH_MIN:    rd_val = cfg.one_high_min;
      REG_ZERO_HIGH_MAX:   rd_val = cfg.zero_high_max;
      REG_BIT_HIGH_MAX:    rd_val = cfg.bit_high_max;
      default:             rd_val = '0;
    endcase
  end

  assign prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, rd_val};

endmodule

// ===== hdl/ipdfr_decoder.sv =====
module ipdfr_decoder
  import ipdfr_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   ir_level,
  input  cfg_t   cfg,
  output frame_t frame
);

  localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_LEAD_LOW  = 6'b000010,
    PH_LEAD_HIGH = 6'b000100,
    PH_FIRST_LOW = 6'b001000,
    PH_BIT       = 6'b010000,
    PH_GAP       = 6'b100000
  } phase_t;

  phase_t            phase, phase_next;
  logic [TICK_W-1:0] low_ticks, low_ticks_next;
  logic [TICK_W-1:0] high_ticks, high_ticks_next;
  logic              bit_taken, bit_taken_next;
  logic [3:0]        bits_in_byte, bits_in_byte_next;
  logic [IDX_W-1:0]  bytes_in_frame, bytes_in_frame_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [7:0]        frame_store [FRAME_BYTES];

  logic is_low;
  logic take_bit;
  logic bit_val;
  logic bad_high;
  logic store_wr;
  logic last_byte;

  assign is_low = !ir_level;

  // next state for one line sample
  always_comb begin
    phase_next          = phase;
    low_ticks_next      = low_ticks;
    high_ticks_next     = high_ticks;
    bit_taken_next      = bit_taken;
    bits_in_byte_next   = bits_in_byte;
    bytes_in_frame_next = bytes_in_frame;
    shift_byte_next     = shift_byte;
    take_bit            = 1'b0;
    bit_val             = 1'b0;
    bad_high            = 1'b0;
    store_wr            = 1'b0;
    last_byte           = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (is_low) begin
          low_ticks_next  = '0;
          high_ticks_next = '0;
          phase_next      = PH_LEAD_LOW;
        end
      end
      PH_LEAD_LOW: begin
        if (is_low) begin
          low_ticks_next = bump(low_ticks);
          if (low_ticks_next > cfg.leader_low_max) begin
            phase_next = PH_IDLE;
          end
        end else begin
          phase_next = (low_ticks < cfg.leader_low_min) ? PH_IDLE : PH_LEAD_HIGH;
        end
      end
      PH_LEAD_HIGH: begin
        if (is_low) begin
          if (high_ticks < cfg.leader_high_min) begin
            phase_next = PH_IDLE;
          end else begin
            phase_next          = PH_FIRST_LOW;
            bit_taken_next      = 1'b0;
            bits_in_byte_next   = '0;
            bytes_in_frame_next = '0;
            low_ticks_next      = TICK_W'(1);
            high_ticks_next     = '0;
          end
        end else begin
          high_ticks_next = bump(high_ticks);
          if (high_ticks_next > cfg.leader_high_max) begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_FIRST_LOW: begin
        // no timeout; count carries into bit decoding
        if (is_low) begin
          low_ticks_next = bump(low_ticks);
        end else begin
          high_ticks_next = TICK_W'(1);
          phase_next      = PH_BIT;
        end
      end
      PH_BIT: begin
        if (is_low) begin
          low_ticks_next = bump(low_ticks);
          if (low_ticks_next > cfg.bit_low_max) begin
            phase_next = PH_IDLE;
          end else begin
            // classify the preceding high
            if (!bit_taken) begin
              if (high_ticks >= cfg.one_high_min) begin
                take_bit = 1'b1;
                bit_val  = 1'b1;
              end else if (high_ticks >= ZERO_HIGH_MIN &&
                           high_ticks <= cfg.zero_high_max) begin
                take_bit = 1'b1;
              end else begin
                bad_high = 1'b1;
              end
            end
            if (bad_high) begin
              phase_next = PH_IDLE;
            end else begin
              high_ticks_next = '0;
              if (take_bit) begin
                shift_byte_next   = {shift_byte[6:0], bit_val};
                bit_taken_next    = 1'b1;
                bits_in_byte_next = bits_in_byte + 1'b1;
              end
              // byte complete
              if (bits_in_byte_next >= BYTE_BITS) begin
                bits_in_byte_next = '0;
                store_wr          = 1'b1;
                if (bytes_in_frame >= LAST_IDX) begin
                  bytes_in_frame_next = '0;
                  phase_next          = PH_GAP;
                  last_byte           = 1'b1;
                end else begin
                  bytes_in_frame_next = bytes_in_frame + 1'b1;
                end
              end
            end
          end
        end else begin
          high_ticks_next = bump(high_ticks);
          if (high_ticks_next > cfg.bit_high_max) begin
            phase_next = PH_IDLE;
          end else begin
            bit_taken_next = 1'b0;
            low_ticks_next = '0;
          end
        end
      end
      PH_GAP: begin
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      low_ticks      <= '0;
      high_ticks     <= '0;
      bit_taken      <= 1'b0;
      bits_in_byte   <= '0;
      bytes_in_frame <= '0;
      shift_byte     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      low_ticks      <= low_ticks_next;
      high_ticks     <= high_ticks_next;
      bit_taken      <= bit_taken_next;
      bits_in_byte   <= bits_in_byte_next;
      bytes_in_frame <= bytes_in_frame_next;
      shift_byte     <= shift_byte_next;
    end
  end

  // received byte store
  always_ff @(posedge clk) begin
    if (step && store_wr) begin
      frame_store[bytes_in_frame] <= shift_byte_next;
    end
  end

  // frame view: earlier bytes from the store, last byte straight from the shifter
  always_comb begin
    frame.fire = step && last_byte;
    for (int k = 0; k < MAX_FRAME_BYTES; k++) begin
      if (k == FRAME_BYTES - 1) begin
        frame.data[k] = shift_byte_next;
      end else if (k < FRAME_BYTES - 1) begin
        frame.data[k] = frame_store[k];
      end else begin
        frame.data[k] = '0;
      end
    end
  end

endmodule

// ===== hdl/ipdfr_format.sv =====
module ipdfr_format
  import ipdfr_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  frame_t     frame,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] start_byte,
  output logic [7:0] data_byte_one,
  output logic [7:0] data_byte_two,
  output logic [7:0] data_byte_three,
  output logic [7:0] data_byte_four,
  output logic [7:0] check_byte,
  output logic       sum_ok
);

  logic [4:0][7:0] field;
  logic [7:0]      chk;
  logic [7:0]      sum;

  // bit reversal and checksum of the completed frame
  always_comb begin
    chk = flip8(frame.data[FRAME_BYTES-1]);
    sum = '0;
    for (int k = 0; k < 5; k++) begin
      field[k] = (k < FRAME_BYTES - 1) ? flip8(frame.data[k]) : 8'h00;
    end
    for (int k = 1; k < MAX_FRAME_BYTES; k++) begin
      if (k < FRAME_BYTES - 1) begin
        sum = sum + flip8(frame.data[k]);
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= frame.fire || (out_valid && out_stall);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (frame.fire) begin
      start_byte      <= field[0];
      data_byte_one   <= field[1];
      data_byte_two   <= field[2];
      data_byte_three <= field[3];
      data_byte_four  <= field[4];
      check_byte      <= chk;
      sum_ok          <= (sum == chk);
    end
  end

endmodule

// ===== hdl/ipdfr_checker.sv =====
module ipdfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] start_byte,
  input logic [7:0] check_byte
);

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // a held result blocks new samples
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("sample accepted while result held");

  // a new result needs a sample accepted just before
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without accepted sample");

  // a frame is followed by an idle tick, so results never come back to back
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("results back to back");

  // stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(start_byte) && $stable(check_byte)))
    else $error("stalled result changed");

endmodule

bind ir_pulse_distance_frame_receiver ipdfr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .start_byte (start_byte),
  .check_byte (check_byte)
);

// ===== tb/tb_ir_pulse_distance_frame_receiver.sv =====
`timescale 1ns / 100ps

module tb_ir_pulse_distance_frame_receiver;
  import ipdfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned FRAME_LEN   = DEF_FRAME_BYTES;
  localparam int unsigned FRAME_BITS  = 8 * DEF_FRAME_BYTES;

  // decoder phases as the line is walked tick by tick
  typedef enum logic [2:0] {
    LINE_IDLE,
    LEAD_LOW,
    LEAD_HIGH,
    FIRST_LOW,
    BIT_DECODE,
    FRAME_GAP
  } line_phase_e;

  // ways a generated frame can be spoiled
  typedef enum int {
    FLT_NONE,
    FLT_LEAD_LOW_SHORT,
    FLT_LEAD_LOW_LONG,
    FLT_LEAD_HIGH_SHORT,
    FLT_LEAD_HIGH_LONG,
    FLT_FIRST_LOW_LONG,
    FLT_BIT_LOW_LONG,
    FLT_BIT_HIGH_LONG,
    FLT_BIT_HIGH_ONE,
    FLT_BIT_HIGH_GAP,
    FLT_CUT
  } fault_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic [7:0] data_three;
    logic [7:0] data_four;
    logic [7:0] check;
    logic       sum_ok;
  } frame_result_t;

  // tracks the decoder state per line sample and checks the frames that come out
  class ir_frame_checker;
    cfg_t          win;
    line_phase_e   phase;
    logic [5:0]    low_ticks;
    logic [5:0]    high_ticks;
    logic          bit_taken;
    logic [3:0]    bits_in_byte;
    logic [2:0]    bytes_in_frame;
    logic [7:0]    shift_byte;
    logic [7:0]    store [8];
    frame_result_t pending_frames [$];
    int unsigned   samples;
    int unsigned   frames;
    int unsigned   results;
    int unsigned   mismatches;

    function new();
      win.leader_low_min  = RST_LEADER_LOW_MIN;
      win.leader_low_max  = RST_LEADER_LOW_MAX;
      win.leader_high_min = RST_LEADER_HIGH_MIN;
      win.leader_high_max = RST_LEADER_HIGH_MAX;
      win.bit_low_max     = RST_BIT_LOW_MAX;
      win.one_high_min    = RST_ONE_HIGH_MIN;
      win.zero_high_max   = RST_ZERO_HIGH_MAX;
      win.bit_high_max    = RST_BIT_HIGH_MAX;
      phase = LINE_IDLE;
      low_ticks = '0;
      high_ticks = '0;
      bit_taken = 1'b0;
      bits_in_byte = '0;
      bytes_in_frame = '0;
      shift_byte = '0;
      foreach (store[k]) store[k] = '0;
      samples = 0;
      frames = 0;
      results = 0;
      mismatches = 0;
    endfunction

    function void set_window(logic [2:0] idx, logic [5:0] val);
      case (idx)
        REG_LEADER_LOW_MIN:  win.leader_low_min = val;
        REG_LEADER_LOW_MAX:  win.leader_low_max = val;
        REG_LEADER_HIGH_MIN: win.leader_high_min = val;
        REG_LEADER_HIGH_MAX: win.leader_high_max = val;
        REG_BIT_LOW_MAX:     win.bit_low_max = val;
        REG_ONE_HIGH_MIN:    win.one_high_min = val;
        REG_ZERO_HIGH_MAX:   win.zero_high_max = val;
        REG_BIT_HIGH_MAX:    win.bit_high_max = val;
        default: ;
      endcase
    endfunction

    function logic [5:0] tick_up(logic [5:0] v);
      return (v == TICK_MAX) ? v : v + 6'd1;
    endfunction

    function int unsigned pending();
      return pending_frames.size();
    endfunction

    // bytes come out bit reversed, check flag over the data bytes
    function void push_frame();
      frame_result_t e;
      logic [7:0]    r [8];
      logic [7:0]    sum;
      for (int k = 0; k < 8; k++) r[k] = {<<{store[k]}};
      sum = r[1] + r[2] + r[3] + r[4];
      e.start_byte = r[0];
      e.data_one   = r[1];
      e.data_two   = r[2];
      e.data_three = r[3];
      e.data_four  = r[4];
      e.check      = r[FRAME_LEN-1];
      e.sum_ok     = (sum == r[FRAME_LEN-1]);
      pending_frames.push_back(e);
      frames++;
    endfunction

    function void note_sample(logic level);
      logic low;
      low = !level;
      samples++;
      case (phase)
        LINE_IDLE:
          if (low) begin
            low_ticks = '0;
            high_ticks = '0;
            phase = LEAD_LOW;
          end
        LEAD_LOW:
          if (low) begin
            low_ticks = tick_up(low_ticks);
            if (low_ticks > win.leader_low_max) phase = LINE_IDLE;
          end else begin
            phase = (low_ticks < win.leader_low_min) ? LINE_IDLE : LEAD_HIGH;
          end
        LEAD_HIGH:
          if (low) begin
            if (high_ticks < win.leader_high_min) begin
              phase = LINE_IDLE;
            end else begin
              phase = FIRST_LOW;
              bit_taken = 1'b0;
              bits_in_byte = '0;
              bytes_in_frame = '0;
              low_ticks = 6'd1;
              high_ticks = '0;
            end
          end else begin
            high_ticks = tick_up(high_ticks);
            if (high_ticks > win.leader_high_max) phase = LINE_IDLE;
          end
        FIRST_LOW:
          if (low) begin
            low_ticks = tick_up(low_ticks);
          end else begin
            high_ticks = 6'd1;
            phase = BIT_DECODE;
          end
        BIT_DECODE:
          if (low) begin
            low_ticks = tick_up(low_ticks);
            // timeout beats a bit decoded on the same tick
            if (low_ticks > win.bit_low_max) begin
              phase = LINE_IDLE;
            end else if (!bit_taken && high_ticks < win.one_high_min &&
                         !(high_ticks >= ZERO_HIGH_MIN && high_ticks <= win.zero_high_max)) begin
              phase = LINE_IDLE;
            end else begin
              if (!bit_taken) begin
                shift_byte = {shift_byte[6:0], high_ticks >= win.one_high_min};
                bit_taken = 1'b1;
                bits_in_byte++;
              end
              high_ticks = '0;
              if (bits_in_byte >= BYTE_BITS) begin
                bits_in_byte = '0;
                store[bytes_in_frame] = shift_byte;
                bytes_in_frame++;
                if (bytes_in_frame >= FRAME_LEN) begin
                  bytes_in_frame = '0;
                  phase = FRAME_GAP;
                  push_frame();
                end
              end
            end
          end else begin
            high_ticks = tick_up(high_ticks);
            if (high_ticks > win.bit_high_max) begin
              phase = LINE_IDLE;
            end else begin
              bit_taken = 1'b0;
              low_ticks = '0;
            end
          end
        default: phase = LINE_IDLE;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame %0d %s: expected %02h, got %02h", results, name, want, got);
      end
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      results++;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame %0d: result %h arrived with none pending", results, got);
        return;
      end
      want = pending_frames.pop_front();
      compare_field("start_byte", want.start_byte, got.start_byte);
      compare_field("data_byte_one", want.data_one, got.data_one);
      compare_field("data_byte_two", want.data_two, got.data_two);
      compare_field("data_byte_three", want.data_three, got.data_three);
      compare_field("data_byte_four", want.data_four, got.data_four);
      compare_field("check_byte", want.check, got.check);
      compare_field("sum_ok", {7'd0, want.sum_ok}, {7'd0, got.sum_ok});
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  ir_level = 1'b1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            start_byte;
  logic [7:0]            data_byte_one;
  logic [7:0]            data_byte_two;
  logic [7:0]            data_byte_three;
  logic [7:0]            data_byte_four;
  logic [7:0]            check_byte;
  logic                  sum_ok;

  ir_frame_checker sb;
  bit              line_quiet = 1'b0;
  bit              take_quiet = 1'b0;
  int unsigned     cycles = 0;

  ir_pulse_distance_frame_receiver u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .ir_level        (ir_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .start_byte      (start_byte),
    .data_byte_one   (data_byte_one),
    .data_byte_two   (data_byte_two),
    .data_byte_three (data_byte_three),
    .data_byte_four  (data_byte_four),
    .check_byte      (check_byte),
    .sum_ok          (sum_ok)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // per item wait, with stretches of back to back traffic
  function automatic int unsigned draw_gap(inout bit quiet, input int unsigned odds);
    if ($urandom_range(odds - 1, 0) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(18, 0);
  endfunction

  // tick count in a window, mostly near the low end, sometimes the top
  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    int unsigned v;
    if (hi <= lo) begin
      v = lo;
    end else begin
      case ($urandom_range(7, 0))
        0:       v = hi;
        1, 2:    v = $urandom_range(hi, lo);
        default: v = $urandom_range((hi > lo + 3) ? lo + 3 : hi, lo);
      endcase
    end
    return v;
  endfunction

  function automatic cfg_t windows(input int unsigned llmin, llmax, lhmin, lhmax,
                                   input int unsigned blmax, ohmin, zhmax, bhmax);
    cfg_t w;
    w.leader_low_min  = llmin[5:0];
    w.leader_low_max  = llmax[5:0];
    w.leader_high_min = lhmin[5:0];
    w.leader_high_max = lhmax[5:0];
    w.bit_low_max     = blmax[5:0];
    w.one_high_min    = ohmin[5:0];
    w.zero_high_max   = zhmax[5:0];
    w.bit_high_max    = bhmax[5:0];
    return w;
  endfunction

  // frame content as it comes out, half of them with a matching sum
  function automatic logic [5:0][7:0] random_frame();
    logic [5:0][7:0] b;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(5, 0))
        0:       b[i] = 8'h00;
        1:       b[i] = 8'hff;
        default: b[i] = $urandom_range(255, 0);
      endcase
    end
    if ($urandom_range(1, 0) == 1) b[5] = b[1] + b[2] + b[3] + b[4];
    return b;
  endfunction

  task automatic send_sample(logic level);
    int unsigned hold;
    hold = draw_gap(line_quiet, 48);
    if (hold > 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid <= 1'b1;
    ir_level <= level;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_sample(level);
  endtask

  task automatic send_run(logic level, int unsigned count);
    repeat (count) send_sample(level);
  endtask

  // leader, then the frame bits sent lsb of each output byte first
  task automatic send_frame(logic [5:0][7:0] bytes, fault_e fault);
    cfg_t        w;
    int unsigned lows, highs, bad, one_lo, zero_top;
    w = sb.win;
    bad = $urandom_range(FRAME_BITS - 1, 1);
    one_lo = (w.one_high_min > 0) ? w.one_high_min : 1;
    zero_top = w.zero_high_max;
    if (w.one_high_min <= zero_top) zero_top = (w.one_high_min > 0) ? w.one_high_min - 1 : 0;
    if (w.bit_high_max < zero_top) zero_top = w.bit_high_max;

    // leader low
    lows = pick(w.leader_low_min, w.leader_low_max);
    if (fault == FLT_LEAD_LOW_SHORT && w.leader_low_min > 0)
      lows = $urandom_range(w.leader_low_min - 1, 0);
    if (fault == FLT_LEAD_LOW_LONG) lows = w.leader_low_max + $urandom_range(9, 1);
    send_run(1'b0, lows + 1);

    // leader high
    highs = pick(w.leader_high_min, w.leader_high_max);
    if (fault == FLT_LEAD_HIGH_SHORT && w.leader_high_min > 0)
      highs = $urandom_range(w.leader_high_min - 1, 0);
    if (fault == FLT_LEAD_HIGH_LONG) highs = w.leader_high_max + $urandom_range(9, 1);
    send_run(1'b1, highs + 1);

    // data bits
    for (int i = 0; i < FRAME_BITS; i++) begin
      lows = (i == 0 && fault == FLT_FIRST_LOW_LONG) ? $urandom_range(70, 8)
                                                      : pick(1, w.bit_low_max);
      if (i == bad && fault == FLT_BIT_LOW_LONG) lows = w.bit_low_max + $urandom_range(4, 1);
      send_run(1'b0, lows);
      highs = bytes[i / 8][i % 8] ? pick(one_lo, w.bit_high_max) : pick(2, zero_top);
      if (i == bad) begin
        case (fault)
          FLT_BIT_HIGH_LONG: highs = w.bit_high_max + $urandom_range(4, 1);
          FLT_BIT_HIGH_ONE:  highs = 1;
          FLT_BIT_HIGH_GAP:  highs = w.zero_high_max + 1;
          default: ;
        endcase
      end
      send_run(1'b1, highs);
      if (fault == FLT_CUT && i == bad) break;
    end

    // closing low decodes the last bit, then the line rests
    if (fault != FLT_CUT) send_run(1'b0, 1);
    send_run(1'b1, $urandom_range(4, 1));
  endtask

  task automatic random_traffic(int unsigned item_goal, int unsigned frame_goal,
                                int unsigned item_cap);
    int unsigned s0, f0, roll;
    s0 = sb.samples;
    f0 = sb.frames;
    while (((sb.samples - s0) < item_goal || (sb.frames - f0) < frame_goal) &&
           (sb.samples - s0) < item_cap) begin
      roll = $urandom_range(9, 0);
      if (roll < 7) begin
        send_frame(random_frame(), FLT_NONE);
      end else if (roll < 9) begin
        send_frame(random_frame(), fault_e'($urandom_range(FLT_CUT, FLT_LEAD_LOW_SHORT)));
      end else begin
        repeat ($urandom_range(5, 1)) send_run($urandom_range(1, 0), $urandom_range(12, 1));
      end
    end
  endtask

  // stop the line and let every pending frame come out
  task automatic settle_line();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [5:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_window(idx, val);
  endtask

  task automatic load_windows(cfg_t w);
    write_reg(REG_LEADER_LOW_MIN, w.leader_low_min);
    write_reg(REG_LEADER_LOW_MAX, w.leader_low_max);
    write_reg(REG_LEADER_HIGH_MIN, w.leader_high_min);
    write_reg(REG_LEADER_HIGH_MAX, w.leader_high_max);
    write_reg(REG_BIT_LOW_MAX, w.bit_low_max);
    write_reg(REG_ONE_HIGH_MIN, w.one_high_min);
    write_reg(REG_ZERO_HIGH_MAX, w.zero_high_max);
    write_reg(REG_BIT_HIGH_MAX, w.bit_high_max);
  endtask

  // result side: random stall before each item
  initial begin : result_sink
    int unsigned   hold;
    frame_result_t got;
    forever begin
      hold = draw_gap(take_quiet, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (rst || out_valid !== 1'b1 || out_stall);
      got = {start_byte, data_byte_one, data_byte_two, data_byte_three,
             data_byte_four, check_byte, sum_ok};
      sb.check_frame(got);
    end
  end

  initial begin : stimulus
    int unsigned llmin, lhmin, zhmax, ohmin;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed frames under reset windows: byte extremes, sum wrap, each spoiled case
    send_frame({8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h00}, FLT_NONE);
    send_frame({6{8'hff}}, FLT_NONE);
    for (int f = FLT_LEAD_LOW_SHORT; f <= FLT_CUT; f++) send_frame(random_frame(), fault_e'(f));

    random_traffic(1750, 8, 30000);
    settle_line();

    // short windows, quick frames
    load_windows(windows(2, 6, 2, 6, 2, 5, 3, 7));
    random_traffic(0, 20, 30000);
    settle_line();

    // all windows closed: no frame can finish
    load_windows(windows(0, 0, 0, 0, 0, 0, 0, 0));
    random_traffic(400, 0, 400);
    settle_line();

    // all windows at the top: counters saturate
    load_windows(windows(63, 63, 63, 63, 63, 63, 63, 63));
    random_traffic(0, 2, 25000);
    settle_line();

    // random sensible windows
    repeat (3) begin
      llmin = $urandom_range(10, 0);
      lhmin = $urandom_range(10, 0);
      zhmax = $urandom_range(6, 2);
      ohmin = zhmax + $urandom_range(4, 1);
      load_windows(windows(llmin, llmin + $urandom_range(10, 0), lhmin,
                           lhmin + $urandom_range(10, 0), $urandom_range(6, 1), ohmin,
                           zhmax, ohmin + $urandom_range(4, 0)));
      random_traffic(0, 4, 20000);
      settle_line();
    end

    // arbitrary windows, mostly rejected traffic
    load_windows(windows($urandom_range(63, 0), $urandom_range(63, 0), $urandom_range(63, 0),
                         $urandom_range(63, 0), $urandom_range(63, 0), $urandom_range(63, 0),
                         $urandom_range(63, 0), $urandom_range(63, 0)));
    random_traffic(600, 0, 600);
    settle_line();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
